// ===== design/varint_stream_codec_core_macros.svh =====
// Assertion macros of the varint stream codec, used by vsc_ctrl.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef VARINT_STREAM_CODEC_CORE_MACROS_SVH
`define VARINT_STREAM_CODEC_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VSC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/vsc_pkg.sv =====
// Types and constants of the varint stream codec.
// Used by the controller, the datapath and the top level; depends on nothing.
package vsc_pkg;

  localparam logic [7:0]  GROUP_MASK    = 8'h7F;
  localparam logic [7:0]  CONT_FLAG     = 8'h80;
  localparam logic [63:0] ENC_HIGH_MASK = ~64'h7F;

  localparam logic [3:0] LIMIT_NARROW = 4'd5;
  localparam logic [3:0] LIMIT_WIDE   = 4'd10;

  localparam logic KIND_DECODE = 1'b0;
  localparam logic KIND_ENCODE = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_OVERRUN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ENC  = 2'b10
  } state_e;

  typedef struct packed {
    logic dec;
    logic enc_first;
    logic enc_next;
  } cmd_t;

  typedef struct packed {
    logic dec_emit;
    logic enc_last;
  } sts_t;

endpackage

// ===== design/vsc_ctrl.sv =====
// Controller of the varint stream codec: handshakes, encode sequencing, output valid.
// Depends on vsc_pkg and varint_stream_codec_core_macros.svh.
`include "varint_stream_codec_core_macros.svh"

module vsc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          kind_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  vsc_pkg::sts_t sts_i,
  output vsc_pkg::cmd_t cmd_o
);

  vsc_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic out_free;
  logic in_acc;

  always_comb begin
    out_free   = !out_valid_q || out_ready_i;
    in_ready_o = (state_q == vsc_pkg::ST_IDLE) && out_free;
    in_acc     = in_valid_i && in_ready_o;

    cmd_o.dec       = in_acc && (kind_i == vsc_pkg::KIND_DECODE);
    cmd_o.enc_first = in_acc && (kind_i == vsc_pkg::KIND_ENCODE);
    cmd_o.enc_next  = (state_q == vsc_pkg::ST_ENC) && out_free;

    if ((cmd_o.dec && sts_i.dec_emit) || cmd_o.enc_first || cmd_o.enc_next) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    state_d = state_q;
    unique case (state_q)
      vsc_pkg::ST_IDLE: begin
        if (cmd_o.enc_first && !sts_i.enc_last) begin
          state_d = vsc_pkg::ST_ENC;
        end
      end
      vsc_pkg::ST_ENC: begin
        if (cmd_o.enc_next && sts_i.enc_last) begin
          state_d = vsc_pkg::ST_IDLE;
        end
      end
      default: state_d = vsc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= vsc_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // While bytes of a value remain, the output register always holds one of them.
  `VSC_ASSERT_SAME(a_enc_holds_byte, state_q == vsc_pkg::ST_ENC, out_valid_q,
                   "encode sequence active without a pending output byte")
  `VSC_ASSERT_SAME(a_one_cmd, cmd_o.enc_next, !cmd_o.dec && !cmd_o.enc_first,
                   "new request taken while encode sequence runs")
  `VSC_ASSERT_NEXT(a_enc_continues, cmd_o.enc_next && !sts_i.enc_last,
                   out_valid_q && (state_q == vsc_pkg::ST_ENC),
                   "encode sequence ended before its last byte")
  `VSC_ASSERT_NEXT(a_dec_emits, cmd_o.dec && sts_i.dec_emit, out_valid_q,
                   "decode result lost")

endmodule

// ===== design/vsc_dp.sv =====
// Datapath of the varint stream codec: decode accumulator, encode shifter, output register.
// Depends on vsc_pkg; driven by commands from vsc_ctrl.
module vsc_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vsc_pkg::cmd_t       cmd_i,
  output vsc_pkg::sts_t       sts_o,
  input  logic                wide_i,
  input  logic [7:0]          in_byte_i,
  input  logic signed [63:0]  in_value_i,
  output logic                is_value_o,
  output logic [7:0]          out_byte_o,
  output logic signed [63:0]  out_value_o,
  output logic                last_o,
  output logic                status_o
);

  logic [63:0] acc_q, acc_d;
  logic [3:0]  gc_q, gc_d;
  logic [63:0] enc_q, enc_d;

  logic        is_value_q, is_value_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic [63:0] out_value_q, out_value_d;
  logic        last_q, last_d;
  logic        status_q, status_d;

  logic [3:0]  limit;
  logic [5:0]  shift;
  logic [63:0] acc_new;
  logic [63:0] dec_value;
  logic        over, full, cont, dec_err;
  logic [63:0] enc_src;
  logic        enc_last;

  always_comb begin
    limit   = wide_i ? vsc_pkg::LIMIT_WIDE : vsc_pkg::LIMIT_NARROW;
    shift   = 6'(({3'b000, gc_q} << 3) - {3'b000, gc_q});
    acc_new = acc_q | ({56'b0, in_byte_i & vsc_pkg::GROUP_MASK} << shift);
    over    = gc_q >= limit;
    full    = (gc_q + 4'd1) >= limit;
    cont    = (in_byte_i & vsc_pkg::CONT_FLAG) != 8'h00;
    dec_err = over || (cont && full);
    sts_o.dec_emit = over || !cont || full;

    if (dec_err) begin
      dec_value = 64'b0;
    end else if (wide_i) begin
      dec_value = acc_new;
    end else begin
      dec_value = {{32{acc_new[31]}}, acc_new[31:0]};
    end

    if (cmd_i.enc_first) begin
      enc_src = wide_i ? in_value_i : {32'b0, in_value_i[31:0]};
    end else begin
      enc_src = enc_q;
    end
    enc_last       = (enc_src & vsc_pkg::ENC_HIGH_MASK) == 64'b0;
    sts_o.enc_last = enc_last;

    acc_d = acc_q;
    gc_d  = gc_q;
    if (cmd_i.dec) begin
      if (sts_o.dec_emit) begin
        acc_d = 64'b0;
        gc_d  = 4'd0;
      end else begin
        acc_d = acc_new;
        gc_d  = gc_q + 4'd1;
      end
    end

    enc_d       = enc_q;
    is_value_d  = is_value_q;
    out_byte_d  = out_byte_q;
    out_value_d = out_value_q;
    last_d      = last_q;
    status_d    = status_q;
    if (cmd_i.dec && sts_o.dec_emit) begin
      is_value_d  = 1'b1;
      out_byte_d  = 8'h00;
      out_value_d = dec_value;
      last_d      = 1'b0;
      status_d    = dec_err ? vsc_pkg::STATUS_OVERRUN : vsc_pkg::STATUS_OK;
    end else if (cmd_i.enc_first || cmd_i.enc_next) begin
      enc_d       = enc_src >> 7;
      is_value_d  = 1'b0;
      out_byte_d  = (enc_src[7:0] & vsc_pkg::GROUP_MASK) |
                    (enc_last ? 8'h00 : vsc_pkg::CONT_FLAG);
      out_value_d = 64'b0;
      last_d      = enc_last;
      status_d    = vsc_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 64'b0;
      gc_q  <= 4'd0;
    end else begin
      acc_q <= acc_d;
      gc_q  <= gc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    enc_q       <= enc_d;
    is_value_q  <= is_value_d;
    out_byte_q  <= out_byte_d;
    out_value_q <= out_value_d;
    last_q      <= last_d;
    status_q    <= status_d;
  end

  assign is_value_o  = is_value_q;
  assign out_byte_o  = out_byte_q;
  assign out_value_o = out_value_q;
  assign last_o      = last_q;
  assign status_o    = status_q;

endmodule

// ===== design/varint_stream_codec_core.sv =====
// LEB128 varint/varlong codec top level: the result of a decode request, if any,
// appears in the output register on the next cycle.
// An encode request of n bytes (1 to 10) emits one byte per cycle from the encode
// shifter while output is free; no new request is taken until its last byte is loaded.
// Reset clears the decode accumulator, the byte count, the sequencer and output valid.
// Depends on vsc_pkg, vsc_ctrl and vsc_dp.
module varint_stream_codec_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic               wide_i,
  input  logic [7:0]         in_byte_i,
  input  logic signed [63:0] in_value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               is_value_o,
  output logic [7:0]         out_byte_o,
  output logic signed [63:0] out_value_o,
  output logic               last_o,
  output logic               status_o
);

  vsc_pkg::cmd_t cmd;
  vsc_pkg::sts_t sts;

  vsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  vsc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .wide_i      (wide_i),
    .in_byte_i   (in_byte_i),
    .in_value_i  (in_value_i),
    .is_value_o  (is_value_o),
    .out_byte_o  (out_byte_o),
    .out_value_o (out_value_o),
    .last_o      (last_o),
    .status_o    (status_o)
  );

endmodule
